// ===== rtl/tcer_pkg.sv =====
// shared types and constants of the ttl answer cache
package tcer_pkg;

   // default number of cache entries
   localparam int DEF_ENTRIES = 8;

   // field widths
   localparam int KEY_W    = 64;
   localparam int TIME_W   = 32;
   localparam int EXPIRY_W = TIME_W + 1;
   localparam int HANDLE_W = 32;
   localparam int SLOT_W   = 3;

   // operation codes
   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } tcer_op_type;

   // request transaction
   typedef struct packed {
      tcer_op_type          op;
      logic [KEY_W-1:0]     lookup_key;
      logic [TIME_W-1:0]    now_seconds;
      logic [TIME_W-1:0]    ttl_seconds;
      logic [HANDLE_W-1:0]  answer_handle;
   } tcer_req_type;

   // response transaction
   typedef struct packed {
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic [TIME_W-1:0]    remaining_ttl;
      logic [HANDLE_W-1:0]  hit_handle;
      logic                 replaced_present;
      logic [KEY_W-1:0]     replaced_key;
   } tcer_rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      tcer_op_type          op;
      logic [KEY_W-1:0]     key;
      logic [TIME_W-1:0]    now_seconds;
      logic [TIME_W-1:0]    ttl_seconds;
      logic [HANDLE_W-1:0]  handle;
      logic                 found;
      logic [EXPIRY_W-1:0]  found_expiry;
      logic [HANDLE_W-1:0]  found_handle;
      logic                 exp_found;
      logic [KEY_W-1:0]     exp_key;
      logic                 empty_found;
      logic                 min_valid;
      logic [EXPIRY_W-1:0]  min_expiry;
      logic [KEY_W-1:0]     min_key;
   } tcer_token_type;

   // entry write broadcast to all cells
   typedef struct packed {
      logic                 en;
      logic [KEY_W-1:0]     key;
      logic [EXPIRY_W-1:0]  expiry;
      logic [HANDLE_W-1:0]  handle;
   } tcer_write_type;

endpackage

// ===== rtl/tcer_cell.sv =====
// one cache entry cell: holds an entry and updates the passing search token
module tcer_cell import tcer_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int INDEX   = 0,
   localparam int IDX_W  = $clog2(ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcer_token_type       left_tok,
   input  logic [IDX_W-1:0]     left_found_idx,
   input  logic [IDX_W-1:0]     left_exp_idx,
   input  logic [IDX_W-1:0]     left_empty_idx,
   input  logic [IDX_W-1:0]     left_min_idx,
   output tcer_token_type       right_tok,
   output logic [IDX_W-1:0]     right_found_idx,
   output logic [IDX_W-1:0]     right_exp_idx,
   output logic [IDX_W-1:0]     right_empty_idx,
   output logic [IDX_W-1:0]     right_min_idx,
   input  tcer_write_type       wr,
   input  logic [IDX_W-1:0]     wr_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic                 present_ff, present_in;
   logic                 expired_ff, expired_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [EXPIRY_W-1:0]  expiry_ff, expiry_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   tcer_token_type       tok_ff, tok_in;
   logic [IDX_W-1:0]     found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]     exp_idx_ff, exp_idx_in;
   logic [IDX_W-1:0]     empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic                 due;

   // entry is at or past its expiry time
   assign due = present_ff && (expiry_ff <= {1'b0, left_tok.now_seconds});

   // token update and entry write
   always_comb begin
      tok_in       = left_tok;
      found_idx_in = left_found_idx;
      exp_idx_in   = left_exp_idx;
      empty_idx_in = left_empty_idx;
      min_idx_in   = left_min_idx;
      present_in   = present_ff;
      expired_in   = expired_ff;
      key_in       = key_ff;
      expiry_in    = expiry_ff;
      handle_in    = handle_ff;
      if (left_tok.valid) begin
         if (left_tok.op == OP_LOOKUP) begin
            // sticky expiry mark, then first live match
            if (due) begin
               expired_in = 1'b1;
            end
            if (!left_tok.found && present_ff && !expired_ff && !due &&
                key_ff == left_tok.key) begin
               tok_in.found        = 1'b1;
               tok_in.found_expiry = expiry_ff;
               tok_in.found_handle = handle_ff;
               found_idx_in        = MY_IDX;
            end
         end else begin
            // victim candidates: first expired, first empty, last smallest expiry
            if (!left_tok.exp_found && present_ff && expired_ff) begin
               tok_in.exp_found = 1'b1;
               tok_in.exp_key   = key_ff;
               exp_idx_in       = MY_IDX;
            end
            if (!left_tok.empty_found && !present_ff) begin
               tok_in.empty_found = 1'b1;
               empty_idx_in       = MY_IDX;
            end
            if (present_ff && (!left_tok.min_valid || expiry_ff <= left_tok.min_expiry)) begin
               tok_in.min_valid  = 1'b1;
               tok_in.min_expiry = expiry_ff;
               tok_in.min_key    = key_ff;
               min_idx_in        = MY_IDX;
            end
         end
      end
      if (wr.en && wr_idx == MY_IDX) begin
         present_in = 1'b1;
         expired_in = 1'b0;
         key_in     = wr.key;
         expiry_in  = wr.expiry;
         handle_in  = wr.handle;
      end
   end

   // control state and token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= 1'b0;
         expired_ff   <= 1'b0;
         tok_ff       <= '0;
         found_idx_ff <= '0;
         exp_idx_ff   <= '0;
         empty_idx_ff <= '0;
         min_idx_ff   <= '0;
      end else begin
         present_ff   <= present_in;
         expired_ff   <= expired_in;
         tok_ff       <= tok_in;
         found_idx_ff <= found_idx_in;
         exp_idx_ff   <= exp_idx_in;
         empty_idx_ff <= empty_idx_in;
         min_idx_ff   <= min_idx_in;
      end
   end

   // entry contents
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      expiry_ff <= expiry_in;
      handle_ff <= handle_in;
   end

   assign right_tok       = tok_ff;
   assign right_found_idx = found_idx_ff;
   assign right_exp_idx   = exp_idx_ff;
   assign right_empty_idx = empty_idx_ff;
   assign right_min_idx   = min_idx_ff;

endmodule

// ===== rtl/ttl_cache_expiry_replace_top.sv =====
// top level of the ttl answer cache: cell chain, response and write-back
//
// A request transaction is taken at a rising edge with start high and busy
// low. op selects a lookup of lookup_key or an insert of a new answer.
// The request travels as a token along a row of ENTRIES cells, one cell
// per cycle; each cell checks its own entry (expiry mark, key match,
// victim candidate) and hands the token on. When the token leaves the last
// cell the response is registered and, for an insert, the chosen entry is
// written through a broadcast to all cells in the same cycle.
// busy is high from acceptance until the token leaves the last cell;
// rsp_strobe rises at the edge where busy falls and holds for one cycle.
// A new request is not taken until busy has fallen.
// The receiver cannot stall: the response is registered as rsp_strobe
// rises, and rsp_item holds it until the next response.
// Reset empties the cache and drops any transaction in flight.
module ttl_cache_expiry_replace_top import tcer_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  tcer_req_type  req_item,
   output logic          rsp_strobe,
   output tcer_rsp_type  rsp_item
);

   localparam int IDX_W = $clog2(ENTRIES);

   tcer_token_type       tok_chain       [ENTRIES+1];
   logic [IDX_W-1:0]     found_idx_chain [ENTRIES+1];
   logic [IDX_W-1:0]     exp_idx_chain   [ENTRIES+1];
   logic [IDX_W-1:0]     empty_idx_chain [ENTRIES+1];
   logic [IDX_W-1:0]     min_idx_chain   [ENTRIES+1];
   logic [ENTRIES-1:0]   tok_valid_vec;

   logic                 busy_ff, busy_in;
   logic                 rsp_strobe_ff;
   tcer_rsp_type         rsp_ff, rsp_in;
   tcer_write_type       wr;
   logic [IDX_W-1:0]     wr_idx;
   logic                 accept;
   tcer_token_type       head_tok;
   tcer_token_type       tail;
   logic [EXPIRY_W-1:0]  diff;
   logic [IDX_W-1:0]     sel_idx;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   assign accept = start && !busy_ff;

   // token injected into the first cell
   always_comb begin
      head_tok             = '0;
      head_tok.valid       = accept;
      head_tok.op          = req_item.op;
      head_tok.key         = req_item.lookup_key;
      head_tok.now_seconds = req_item.now_seconds;
      head_tok.ttl_seconds = req_item.ttl_seconds;
      head_tok.handle      = req_item.answer_handle;
   end
   assign tok_chain[0]       = head_tok;
   assign found_idx_chain[0] = '0;
   assign exp_idx_chain[0]   = '0;
   assign empty_idx_chain[0] = '0;
   assign min_idx_chain[0]   = '0;

   // row of entry cells
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      tcer_cell #(
         .ENTRIES (ENTRIES),
         .INDEX   (g)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .left_tok        (tok_chain[g]),
         .left_found_idx  (found_idx_chain[g]),
         .left_exp_idx    (exp_idx_chain[g]),
         .left_empty_idx  (empty_idx_chain[g]),
         .left_min_idx    (min_idx_chain[g]),
         .right_tok       (tok_chain[g+1]),
         .right_found_idx (found_idx_chain[g+1]),
         .right_exp_idx   (exp_idx_chain[g+1]),
         .right_empty_idx (empty_idx_chain[g+1]),
         .right_min_idx   (min_idx_chain[g+1]),
         .wr              (wr),
         .wr_idx          (wr_idx)
      );
      assign tok_valid_vec[g] = tok_chain[g+1].valid;
   end

   assign tail = tok_chain[ENTRIES];

   // response and write-back from the token leaving the chain
   always_comb begin
      rsp_in    = '0;
      wr        = '0;
      sel_idx   = '0;
      diff      = tail.found_expiry - {1'b0, tail.now_seconds};
      if (tail.op == OP_LOOKUP) begin
         if (tail.found) begin
            sel_idx              = found_idx_chain[ENTRIES];
            rsp_in.hit           = 1'b1;
            rsp_in.remaining_ttl = diff[TIME_W] ? '1 : diff[TIME_W-1:0];
            rsp_in.hit_handle    = tail.found_handle;
         end
      end else begin
         priority if (tail.exp_found) begin
            sel_idx                 = exp_idx_chain[ENTRIES];
            rsp_in.replaced_present = 1'b1;
            rsp_in.replaced_key     = tail.exp_key;
         end else if (tail.empty_found) begin
            sel_idx = empty_idx_chain[ENTRIES];
         end else begin
            sel_idx                 = min_idx_chain[ENTRIES];
            rsp_in.replaced_present = 1'b1;
            rsp_in.replaced_key     = tail.min_key;
         end
         wr.en     = tail.valid;
         wr.key    = tail.key;
         wr.expiry = {1'b0, tail.now_seconds} + {1'b0, tail.ttl_seconds};
         wr.handle = tail.handle;
      end
      slot_wide   = {{SLOT_W{1'b0}}, sel_idx};
      rsp_in.slot = slot_wide[SLOT_W-1:0];
   end
   assign wr_idx = sel_idx;

   // busy from acceptance until the token leaves the last cell
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= tail.valid;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // exactly one token in the chain while a transaction is in flight
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $countones(tok_valid_vec) == 1)
      else $error("token count wrong while busy");

   // no token in the chain while idle
   a_no_token_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> tok_valid_vec == '0)
      else $error("stray token while idle");

   // accepted request makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accept");

   // response only follows a scan
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy_ff))
      else $error("response without a transaction");

   // a hit never reports a replacement
   a_hit_no_replace: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.hit |-> !rsp_ff.replaced_present)
      else $error("hit and replacement together");

endmodule
